// File: sv/lcsl_pkg.sv
// Shared constants, types and helpers for the LRU cache set lookup.
package lcsl_pkg;

    localparam int SETS        = 64;
    localparam int WAYS        = 4;
    localparam int TAG_BITS    = 20;

    localparam int SET_IDX_W   = 6;
    localparam int WAY_FIELD_W = 2;
    localparam int OUTCOME_W   = 2;

    localparam int SET_AW      = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WAY_W       = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int ORD_W       = WAYS * WAY_W;
    localparam int META_W      = WAYS + ORD_W;
    localparam int TAG_ROW_W   = WAYS * TAG_BITS;

    typedef enum logic [OUTCOME_W-1:0] {
        OUT_HIT      = 2'd0,
        OUT_COLD     = 2'd1,
        OUT_CONFLICT = 2'd2
    } t_outcome;

    // Recency list after reset: way p sits at position p, way 0 most recent.
    function automatic logic [ORD_W-1:0] reset_order();
        logic [ORD_W-1:0] ord;
        ord = '0;
        for (int p = 0; p < WAYS; p++) begin
            ord[p*WAY_W +: WAY_W] = WAY_W'(p);
        end
        return ord;
    endfunction

endpackage

// File: sv/lcsl_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module lcsl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic                                      i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/lru_cache_set_lookup.sv
// Set-associative cache lookup with LRU replacement; set state held in two RAMs.
//
// One access is taken when start is high and busy is low. In the accept cycle the
// set's tag row and recency/valid row are read from the RAMs, and in the next cycle
// the ways are compared, the way to use is chosen, the recency/valid row is written
// back (the tag row only on a miss) and the result is registered. busy is high
// during that lookup cycle, so a new access cannot be taken until the last is done.
// The result (o_way, o_outcome) appears for exactly one cycle with o_valid, the
// cycle after the write-back; the receiver cannot stall it. Outcome codes are
// 0 hit, 1 cold miss (an invalid way filled), 2 conflict miss (LRU way refilled).
// Reset clears all valid bits and restores ascending recency order at once
// through a per-set flag, so no clearing pass is needed.
module lru_cache_set_lookup (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [lcsl_pkg::SET_IDX_W-1:0]   i_set_index,
    input  logic [lcsl_pkg::TAG_BITS-1:0]    i_tag,
    output logic                             o_valid,
    output logic [lcsl_pkg::WAY_FIELD_W-1:0] o_way,
    output logic [lcsl_pkg::OUTCOME_W-1:0]   o_outcome
);
    import lcsl_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_LOOK
    } t_state;

    t_state                r_state;
    logic [SET_AW-1:0]     r_set;
    logic [TAG_BITS-1:0]   r_tag;
    logic [SETS-1:0]       r_row_init;
    logic                  r_valid;
    logic [WAY_W-1:0]      r_way;
    t_outcome              r_outcome;

    logic                  take;
    logic                  look;
    logic [TAG_ROW_W-1:0]  tag_rd;
    logic [META_W-1:0]     meta_rd;

    logic [WAYS-1:0]       cur_valid;
    logic [ORD_W-1:0]      cur_order;
    logic [WAYS-1:0]       way_hit;
    logic                  hit_done;
    logic                  cold_done;
    logic [WAY_W-1:0]      found_pos;
    logic [WAY_W-1:0]      sel_way;
    t_outcome              n_outcome;
    logic [ORD_W-1:0]      n_order;
    logic [WAYS-1:0]       n_valid;
    logic [TAG_ROW_W-1:0]  n_tag_row;
    logic                  tag_we;

    assign busy = (r_state == ST_LOOK);
    assign take = start && !busy;
    assign look = (r_state == ST_LOOK);

    lcsl_ram #(
        .WIDTH (TAG_ROW_W),
        .DEPTH (SETS)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (tag_we),
        .i_waddr (r_set),
        .i_wdata (n_tag_row),
        .i_re    (take),
        .i_raddr (i_set_index[SET_AW-1:0]),
        .o_rdata (tag_rd)
    );

    lcsl_ram #(
        .WIDTH (META_W),
        .DEPTH (SETS)
    ) u_meta_ram (
        .i_clk   (i_clk),
        .i_we    (look),
        .i_waddr (r_set),
        .i_wdata ({n_valid, n_order}),
        .i_re    (take),
        .i_raddr (i_set_index[SET_AW-1:0]),
        .o_rdata (meta_rd)
    );

    always_comb begin
        // A set never written since reset reads as all invalid, ascending order.
        if (r_row_init[r_set]) begin
            cur_valid = meta_rd[META_W-1 -: WAYS];
            cur_order = meta_rd[ORD_W-1:0];
        end else begin
            cur_valid = '0;
            cur_order = reset_order();
        end

        for (int w = 0; w < WAYS; w++) begin
            way_hit[w] = cur_valid[w] && (tag_rd[w*TAG_BITS +: TAG_BITS] == r_tag);
        end

        hit_done  = 1'b0;
        cold_done = 1'b0;
        found_pos = WAY_W'(WAYS - 1);
        n_outcome = OUT_CONFLICT;
        for (int p = 0; p < WAYS; p++) begin
            if (!hit_done && way_hit[cur_order[p*WAY_W +: WAY_W]]) begin
                hit_done  = 1'b1;
                found_pos = WAY_W'(p);
                n_outcome = OUT_HIT;
            end
        end
        if (!hit_done) begin
            for (int p = 0; p < WAYS; p++) begin
                if (!cold_done && !cur_valid[cur_order[p*WAY_W +: WAY_W]]) begin
                    cold_done = 1'b1;
                    found_pos = WAY_W'(p);
                    n_outcome = OUT_COLD;
                end
            end
        end

        sel_way = cur_order[found_pos*WAY_W +: WAY_W];

        // Promote: selected way to the front, the ones ahead of it shift back.
        for (int p = 0; p < WAYS; p++) begin
            if (p == 0) begin
                n_order[p*WAY_W +: WAY_W] = sel_way;
            end else if (WAY_W'(p) <= found_pos) begin
                n_order[p*WAY_W +: WAY_W] = cur_order[(p-1)*WAY_W +: WAY_W];
            end else begin
                n_order[p*WAY_W +: WAY_W] = cur_order[p*WAY_W +: WAY_W];
            end
        end

        for (int w = 0; w < WAYS; w++) begin
            n_valid[w] = cur_valid[w] || (sel_way == WAY_W'(w));
            if (sel_way == WAY_W'(w)) begin
                n_tag_row[w*TAG_BITS +: TAG_BITS] = r_tag;
            end else begin
                n_tag_row[w*TAG_BITS +: TAG_BITS] = tag_rd[w*TAG_BITS +: TAG_BITS];
            end
        end

        tag_we = look && (n_outcome != OUT_HIT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_valid    <= 1'b0;
            r_row_init <= '0;
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (take) begin
                        r_state <= ST_LOOK;
                    end
                end
                ST_LOOK: begin
                    r_state           <= ST_IDLE;
                    r_valid           <= 1'b1;
                    r_row_init[r_set] <= 1'b1;
                end
                default: r_state <= ST_IDLE;
            endcase
        end

        // Payload: capture the access, hold the result until the next one.
        if (take) begin
            r_set <= i_set_index[SET_AW-1:0];
            r_tag <= i_tag;
        end
        if (look) begin
            r_way     <= sel_way;
            r_outcome <= n_outcome;
        end
    end

    assign o_valid   = r_valid;
    assign o_way     = WAY_FIELD_W'(r_way);
    assign o_outcome = r_outcome;

endmodule

// File: test/tb_lru_cache_set_lookup.sv
// Self-checking testbench for the LRU cache set lookup: queued accesses, LRU predictor, monitor.
module tb_lru_cache_set_lookup;
    import lcsl_pkg::*;

    localparam int IDLE_PCT       = 35;
    localparam int RANDOM_ACCESSES = 430;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 8;

    typedef struct {
        logic [SET_IDX_W-1:0] set_index;
        logic [TAG_BITS-1:0]  tag;
        bit                   drain;
        bit                   burst;
    } t_access;

    typedef struct {
        logic [WAY_FIELD_W-1:0] way;
        t_outcome               outcome;
    } t_lookup_result;

    logic                   i_clk;
    logic                   i_rst_n     = 1'b0;
    logic                   start       = 1'b0;
    logic                   busy;
    logic [SET_IDX_W-1:0]   i_set_index = '0;
    logic [TAG_BITS-1:0]    i_tag       = '0;
    logic                   o_valid;
    logic [WAY_FIELD_W-1:0] o_way;
    logic [OUTCOME_W-1:0]   o_outcome;

    t_access        access_q[$];
    t_lookup_result result_q[$];
    t_access        cur_access;
    int             mismatches;
    int             quiet_cycles;

    bit                  line_valid [SETS][WAYS];
    logic [TAG_BITS-1:0] line_tag   [SETS][WAYS];
    logic [WAY_W-1:0]    lru_order  [SETS][WAYS];

    lru_cache_set_lookup dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_set_index (i_set_index),
        .i_tag       (i_tag),
        .o_valid     (o_valid),
        .o_way       (o_way),
        .o_outcome   (o_outcome)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Look up one access in the model of the cache and update its state.
    function automatic t_lookup_result lru_lookup(input logic [SET_IDX_W-1:0] s,
                                                  input logic [TAG_BITS-1:0] t);
        t_lookup_result r;
        int             found;
        logic [WAY_W-1:0] w;
        found     = WAYS;
        r.outcome = OUT_HIT;
        for (int p = 0; p < WAYS; p++) begin
            w = lru_order[s][p];
            if (found == WAYS && line_valid[s][w] && line_tag[s][w] == t) found = p;
        end
        if (found == WAYS) begin
            r.outcome = OUT_COLD;
            for (int p = 0; p < WAYS; p++) begin
                if (found == WAYS && !line_valid[s][lru_order[s][p]]) found = p;
            end
            if (found == WAYS) begin
                found     = WAYS - 1;
                r.outcome = OUT_CONFLICT;
            end
            w = lru_order[s][found];
            line_tag[s][w]   = t;
            line_valid[s][w] = 1'b1;
        end
        w = lru_order[s][found];
        // move the accessed way to the front, shifting the more recent ones back
        for (int p = found; p > 0; p--) lru_order[s][p] = lru_order[s][p-1];
        lru_order[s][0] = w;
        r.way = WAY_FIELD_W'(w);
        return r;
    endfunction

    task automatic add_access(input logic [SET_IDX_W-1:0] s, input logic [TAG_BITS-1:0] t,
                              input bit drain, input bit burst);
        t_access a;
        a.set_index = s;
        a.tag       = t;
        a.drain     = drain;
        a.burst     = burst;
        access_q.push_back(a);
    endtask

    // Driver: hold each access until transfer, then present the next one.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) result_q.push_back(lru_lookup(cur_access.set_index,
                                                              cur_access.tag));
            if (!start || !busy) begin
                if (access_q.size() > 0
                        && !(access_q[0].drain && result_q.size() != 0)
                        && (access_q[0].burst || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    cur_access   = access_q.pop_front();
                    start       <= 1'b1;
                    i_set_index <= cur_access.set_index;
                    i_tag       <= cur_access.tag;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: every strobed result must match the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (result_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, got way %0d outcome %0d",
                         $time, o_way, o_outcome);
                mismatches++;
            end else begin
                t_lookup_result exp_r;
                exp_r = result_q.pop_front();
                if (o_way !== exp_r.way) begin
                    $display("%0t: way mismatch, expected %0d, got %0d",
                             $time, exp_r.way, o_way);
                    mismatches++;
                end
                if (o_outcome !== exp_r.outcome) begin
                    $display("%0t: outcome mismatch, expected %0d, got %0d",
                             $time, exp_r.outcome, o_outcome);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        logic [TAG_BITS-1:0]  tag_pool [6];
        logic [SET_IDX_W-1:0] s;
        logic [TAG_BITS-1:0]  t;
        mismatches   = 0;
        quiet_cycles = 0;
        for (int si = 0; si < SETS; si++) begin
            for (int w = 0; w < WAYS; w++) begin
                line_valid[si][w] = 1'b0;
                line_tag[si][w]   = '0;
                lru_order[si][w]  = WAY_W'(w);
            end
        end

        // fill a set, hit the LRU way, then evict three times
        add_access(6'd0,  20'h00000, 1'b0, 1'b0);
        add_access(6'd0,  20'h00000, 1'b0, 1'b0);
        add_access(6'd0,  20'hFFFFF, 1'b0, 1'b0);
        add_access(6'd0,  20'h00001, 1'b0, 1'b0);
        add_access(6'd0,  20'h00002, 1'b0, 1'b0);
        add_access(6'd0,  20'h00000, 1'b0, 1'b0);
        add_access(6'd0,  20'hABCDE, 1'b0, 1'b0);
        add_access(6'd0,  20'hFFFFF, 1'b0, 1'b0);
        add_access(6'd0,  20'h00001, 1'b0, 1'b0);
        add_access(6'd63, 20'hFFFFF, 1'b0, 1'b0);
        add_access(6'd63, 20'hFFFFF, 1'b0, 1'b0);
        add_access(6'd63, 20'h00000, 1'b0, 1'b0);
        add_access(6'd1,  20'h80000, 1'b0, 1'b0);
        add_access(6'd32, 20'h7FFFF, 1'b0, 1'b0);
        add_access(6'd21, 20'h55555, 1'b0, 1'b0);
        add_access(6'd42, 20'hAAAAA, 1'b0, 1'b0);

        // a small tag pool shared by the hot sets mixes hits with conflict misses
        tag_pool[0] = 20'h00000;
        tag_pool[1] = 20'hFFFFF;
        for (int k = 2; k < 6; k++) tag_pool[k] = TAG_BITS'($urandom);
        for (int i = 0; i < RANDOM_ACCESSES; i++) begin
            if ($urandom_range(0, 99) < 70) begin
                s = SET_IDX_W'($urandom_range(0, 3) * 21);
                t = tag_pool[$urandom_range(0, 5)];
            end else begin
                s = SET_IDX_W'($urandom);
                t = TAG_BITS'($urandom);
            end
            add_access(s, t, (i == 0 || i == 300), (i >= 120 && i < 220));
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(posedge i_clk); while (access_q.size() != 0 || result_q.size() != 0 || start);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && result_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// File: sim.f
sv/lcsl_pkg.sv
sv/lcsl_ram.sv
sv/lru_cache_set_lookup.sv
test/tb_lru_cache_set_lookup.sv
